// ----- hdl/qgse_pkg.sv -----
// Shared constants, operation and gate codes, and Q1.15 helper functions
// for the state vector gate engine. No dependencies.
package qgse_pkg;

    // Default store size and reset qubit count
    localparam int MAX_QUBITS_DEF = 10;
    localparam logic [3:0] QUBITS_RESET = 4'd10;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_GATE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Gate codes
    localparam logic [2:0] G_X   = 3'd0;
    localparam logic [2:0] G_Y   = 3'd1;
    localparam logic [2:0] G_Z   = 3'd2;
    localparam logic [2:0] G_H   = 3'd3;
    localparam logic [2:0] G_S   = 3'd4;
    localparam logic [2:0] G_SDG = 3'd5;
    localparam logic [2:0] G_T   = 3'd6;
    localparam logic [2:0] G_TDG = 3'd7;

    // 1/sqrt(2) in Q1.15 and the rounding offset
    localparam logic signed [16:0] INV_SQRT2_Q15 = 17'sd23170;
    localparam logic signed [33:0] ROUND_HALF    = 34'sd16384;

    // Negate with saturation
    function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
        logic signed [15:0] r;
        begin
            if (v == 16'sh8000)
                r = 16'sh7FFF;
            else
                r = -v;
            return r;
        end
    endfunction

    // Round a scaled product to Q1.15 and saturate
    function automatic logic signed [15:0] round_sat(input logic signed [33:0] p);
        logic signed [33:0] r;
        logic signed [15:0] q;
        begin
            r = (p + ROUND_HALF) >>> 15;
            if (r > 34'sd32767)
                q = 16'sh7FFF;
            else if (r < -34'sd32768)
                q = 16'sh8000;
            else
                q = r[15:0];
            return q;
        end
    endfunction

endpackage

// ----- hdl/qubit_gate_state_vector_engine.sv -----
// Top level of the state vector gate engine: amplitude memory, pair sequencer
// and gate datapath. Depends on qgse_pkg.
//
//   port group          dir  role
//   start/busy + op..   in   command beat: write, gate or read of one amplitude
//   read_valid + read_* out  result beat, one cycle, for a read only
//   cfg_we/cfg_wdata    in   qubit count register write
//
// A write lands as it is accepted; a read result shows in the cycle after
// the read is accepted. A gate walks 2^q amplitudes through the single memory
// read port, one read per cycle, then drains through v1, v2 and v3 with busy high.
// A gate whose target is at or above the qubit count leaves busy low.
// Reset clears control and sets the qubit count to 10; memory is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module qubit_gate_state_vector_engine #(
    parameter int MAX_QUBITS = qgse_pkg::MAX_QUBITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             op,
    input  logic [MAX_QUBITS-1:0]  index,
    input  logic signed [15:0]     write_re,
    input  logic signed [15:0]     write_im,
    input  logic [2:0]             gate,
    input  logic [3:0]             target,
    input  logic                   cfg_we,
    input  logic [3:0]             cfg_wdata,
    output logic                   read_valid,
    output logic signed [15:0]     read_re,
    output logic signed [15:0]     read_im
);

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << AW;
    localparam int QW    = $clog2(MAX_QUBITS + 1);

    // Control registers
    logic [3:0]    cfg_reg;
    logic          run_reg, run_next;
    logic [AW-1:0] step_reg, step_next;
    logic [3:0]    tgt_reg;
    logic [2:0]    g_reg;
    logic          v1_reg, v2_reg, v3_reg, rvalid_reg;
    logic          b1_reg;

    // Payload registers
    logic [AW-1:0] addr1_reg, aaddr2_reg, baddr2_reg, baddr3_reg;
    logic [31:0]   rd_data_reg, aw_reg, da_reg, db_reg, wb3_reg;
    logic signed [33:0] p0_reg, p1_reg, p2_reg, p3_reg;

    logic [31:0]   mem [DEPTH];

    logic          accept;
    logic [QW-1:0] act_q;
    logic [AW-1:0] mask, idx_m, stride, pair_k, addr_lo, addr_hi, seq_a, seq_addr;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [31:0]   wr_data, wa, wb;
    logic          gate_go;

    logic signed [15:0] ar, ai, br, bi;
    logic signed [16:0] m0, m1, m2, m3;
    logic [31:0]   da, db;

    assign accept = start && !busy;
    assign busy   = run_reg | v1_reg | v2_reg | v3_reg;

    // Clamp the qubit count to 1..MAX_QUBITS
    always_comb
    begin
        if (cfg_reg == 4'd0)
            act_q = QW'(1);
        else if (int'(cfg_reg) > MAX_QUBITS)
            act_q = QW'(MAX_QUBITS);
        else
            act_q = QW'(cfg_reg);
    end

    assign mask    = (AW'(1) << act_q) - AW'(1);
    assign idx_m   = index & mask;
    assign gate_go = accept && (op == qgse_pkg::OP_GATE) && (int'(target) < int'(act_q));

    // Pair address: insert a zero at the target bit, set it for the b half
    assign stride   = AW'(1) << tgt_reg;
    assign pair_k   = step_reg >> 1;
    assign addr_lo  = pair_k & (stride - AW'(1));
    assign addr_hi  = (pair_k & ~(stride - AW'(1))) << 1;
    assign seq_a    = addr_hi | addr_lo;
    assign seq_addr = step_reg[0] ? (seq_a | stride) : seq_a;

    assign rd_addr = run_reg ? seq_addr : idx_m;

    // Sequencer next state
    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        if (run_reg)
        begin
            step_next = step_reg + AW'(1);
            if (step_reg == mask)
                run_next = 1'b0;
        end
        else if (gate_go)
        begin
            run_next  = 1'b1;
            step_next = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= qgse_pkg::QUBITS_RESET;
            run_reg    <= 1'b0;
            step_reg   <= '0;
            v1_reg     <= 1'b0;
            b1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            run_reg    <= run_next;
            step_reg   <= step_next;
            v1_reg     <= run_reg;
            b1_reg     <= step_reg[0];
            v2_reg     <= v1_reg && b1_reg;
            v3_reg     <= v2_reg;
            rvalid_reg <= accept && (op == qgse_pkg::OP_READ);
        end
    end

    // Operands: a from the captured word, b straight from the memory output
    assign ar = aw_reg[31:16];
    assign ai = aw_reg[15:0];
    assign br = rd_data_reg[31:16];
    assign bi = rd_data_reg[15:0];

    // Select multiplier operands for the scaled gates
    always_comb
    begin
        m0 = '0;
        m1 = '0;
        m2 = '0;
        m3 = '0;
        case (g_reg)
            qgse_pkg::G_H:
            begin
                m0 = 17'(ar) + 17'(br);
                m1 = 17'(ai) + 17'(bi);
                m2 = 17'(ar) - 17'(br);
                m3 = 17'(ai) - 17'(bi);
            end
            qgse_pkg::G_T:
            begin
                m2 = 17'(br) - 17'(bi);
                m3 = 17'(br) + 17'(bi);
            end
            qgse_pkg::G_TDG:
            begin
                m2 = 17'(br) + 17'(bi);
                m3 = 17'(bi) - 17'(br);
            end
            default:
            begin
                m0 = '0;
            end
        endcase
    end

    // Direct results for the unscaled gates
    always_comb
    begin
        da = aw_reg;
        db = rd_data_reg;
        case (g_reg)
            qgse_pkg::G_X:
            begin
                da = rd_data_reg;
                db = aw_reg;
            end
            qgse_pkg::G_Y:
            begin
                da = {bi, qgse_pkg::neg16(br)};
                db = {qgse_pkg::neg16(ai), ar};
            end
            qgse_pkg::G_Z:   db = {qgse_pkg::neg16(br), qgse_pkg::neg16(bi)};
            qgse_pkg::G_S:   db = {qgse_pkg::neg16(bi), br};
            qgse_pkg::G_SDG: db = {bi, qgse_pkg::neg16(br)};
            default:         db = rd_data_reg;
        endcase
    end

    // Final words of a pair after rounding
    always_comb
    begin
        wa = da_reg;
        wb = db_reg;
        case (g_reg)
            qgse_pkg::G_H:
            begin
                wa = {qgse_pkg::round_sat(p0_reg), qgse_pkg::round_sat(p1_reg)};
                wb = {qgse_pkg::round_sat(p2_reg), qgse_pkg::round_sat(p3_reg)};
            end
            qgse_pkg::G_T, qgse_pkg::G_TDG:
                wb = {qgse_pkg::round_sat(p2_reg), qgse_pkg::round_sat(p3_reg)};
            default:
                wa = da_reg;
        endcase
    end

    // Write port: a then b of a pair, else a command write
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_m;
        wr_data = {write_re, write_im};
        if (v2_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = aaddr2_reg;
            wr_data = wa;
        end
        else if (v3_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = baddr3_reg;
            wr_data = wb3_reg;
        end
        else if (accept && (op == qgse_pkg::OP_WRITE))
        begin
            wr_en = 1'b1;
        end
    end

    // Amplitude memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Datapath pipeline registers
    always_ff @(posedge clk)
    begin
        if (gate_go)
        begin
            tgt_reg <= target;
            g_reg   <= gate;
        end
        addr1_reg <= seq_addr;
        if (v1_reg && !b1_reg)
            aw_reg <= rd_data_reg;
        if (v1_reg && b1_reg)
        begin
            p0_reg     <= m0 * qgse_pkg::INV_SQRT2_Q15;
            p1_reg     <= m1 * qgse_pkg::INV_SQRT2_Q15;
            p2_reg     <= m2 * qgse_pkg::INV_SQRT2_Q15;
            p3_reg     <= m3 * qgse_pkg::INV_SQRT2_Q15;
            da_reg     <= da;
            db_reg     <= db;
            aaddr2_reg <= addr1_reg & ~stride;
            baddr2_reg <= addr1_reg;
        end
        if (v2_reg)
        begin
            wb3_reg    <= wb;
            baddr3_reg <= baddr2_reg;
        end
    end

    assign read_valid = rvalid_reg;
    assign read_re    = rd_data_reg[31:16];
    assign read_im    = rd_data_reg[15:0];

`ifndef SYNTH
    // The two write-back beats of a pair never collide
    a_wb_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(v2_reg && v3_reg))
        else $error("pair write-back beats overlap");

    // A b beat always follows the a beat of the same pair
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && b1_reg) |-> $past(v1_reg && !b1_reg))
        else $error("b amplitude arrived without its a amplitude");

    // A result beat only follows an accepted read
    a_read_src: assert property (@(posedge clk) disable iff (!rst_n)
        read_valid |-> $past(start && !busy && op == qgse_pkg::OP_READ))
        else $error("result beat without a read command");

    // The b write-back follows the a write-back
    a_wb_order: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> $past(v2_reg))
        else $error("b write-back without a write-back");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the state vector gate engine: drives write, gate
// and read commands and checks every read beat. Depends on qgse_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

    typedef struct packed
    {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } amp_t;

    // Scoreboard: own copy of the amplitude store and qubit count, plus the
    // queue of amplitudes that pending reads must return
    class state_vector_model;
        amp_t       amps [1024];
        bit         known [1024];
        logic [3:0] qubit_reg;
        amp_t       pending_reads [$];
        int         errors;
        int         shown;

        function new();
            qubit_reg = qgse_pkg::QUBITS_RESET;
            errors = 0;
            shown = 0;
            foreach (amps[i])
            begin
                amps[i] = '0;
                known[i] = 1'b0;
            end
        endfunction

        function void set_qubits(logic [3:0] v);
            qubit_reg = v;
        endfunction

        // Zero acts as one qubit, anything above the store size as the maximum
        function int live_qubits();
            if (qubit_reg < 1)
                return 1;
            if (qubit_reg > qgse_pkg::MAX_QUBITS_DEF)
                return qgse_pkg::MAX_QUBITS_DEF;
            return qubit_reg;
        endfunction

        function int pending_count();
            return pending_reads.size();
        endfunction

        // First written entry at or after ix, wrapping within the live size, or -1
        function int pick_known(int ix);
            int n;
            int k;
            int j;
            n = 1 << live_qubits();
            for (k = 0; k < n; k++)
            begin
                j = (ix + k) & (n - 1);
                if (known[j])
                    return j;
            end
            return -1;
        endfunction

        function logic signed [15:0] clip(longint v);
            if (v > 32767)
                return 16'sh7FFF;
            if (v < -32768)
                return 16'sh8000;
            return 16'(v);
        endfunction

        function logic signed [15:0] negate(logic signed [15:0] v);
            return clip(-longint'(v));
        endfunction

        // Multiply by 1/sqrt(2): round half up, floor shift, saturate
        function logic signed [15:0] mul_k(longint v);
            longint p;
            p = v * longint'(qgse_pkg::INV_SQRT2_Q15) + 16384;
            return clip(p >>> 15);
        endfunction

        // Update one pair: a has the target bit clear, b has it set
        function void gate_pair(logic [2:0] g, int ia, int ib);
            amp_t   a;
            amp_t   b;
            longint ar;
            longint ai;
            longint br;
            longint bi;
            bit     ka;
            bit     kb;
            a = amps[ia];
            b = amps[ib];
            ar = longint'(a.re);
            ai = longint'(a.im);
            br = longint'(b.re);
            bi = longint'(b.im);
            ka = known[ia];
            kb = known[ib];
            case (g)
                qgse_pkg::G_X:
                begin
                    amps[ia] = b;
                    amps[ib] = a;
                end
                qgse_pkg::G_Y:
                begin
                    amps[ia] = '{b.im, negate(b.re)};
                    amps[ib] = '{negate(a.im), a.re};
                end
                qgse_pkg::G_Z:   amps[ib] = '{negate(b.re), negate(b.im)};
                qgse_pkg::G_H:
                begin
                    amps[ia] = '{mul_k(ar + br), mul_k(ai + bi)};
                    amps[ib] = '{mul_k(ar - br), mul_k(ai - bi)};
                end
                qgse_pkg::G_S:   amps[ib] = '{negate(b.im), b.re};
                qgse_pkg::G_SDG: amps[ib] = '{b.im, negate(b.re)};
                qgse_pkg::G_T:   amps[ib] = '{mul_k(br - bi), mul_k(br + bi)};
                default: amps[ib] = '{mul_k(br + bi), mul_k(bi - br)};
            endcase
            // Track which entries hold defined data after the pair update
            case (g)
                qgse_pkg::G_X, qgse_pkg::G_Y:
                begin
                    known[ia] = kb;
                    known[ib] = ka;
                end
                qgse_pkg::G_H:
                begin
                    known[ia] = ka && kb;
                    known[ib] = ka && kb;
                end
                default: ;
            endcase
        endfunction

        // Advance the store by one accepted command beat
        function void note_beat(logic [1:0] o, logic [9:0] ix, logic signed [15:0] wre,
                                logic signed [15:0] wim, logic [2:0] g, logic [3:0] tgt);
            int q;
            int pos;
            int stride;
            int i;
            q = live_qubits();
            pos = int'(ix) & ((1 << q) - 1);
            case (o)
                qgse_pkg::OP_WRITE:
                begin
                    amps[pos] = '{wre, wim};
                    known[pos] = 1'b1;
                end
                qgse_pkg::OP_GATE:
                begin
                    if (tgt < q)
                    begin
                        stride = 1 << tgt;
                        for (i = 0; i < (1 << q); i++)
                            if ((i & stride) == 0)
                                gate_pair(g, i, i | stride);
                    end
                end
                qgse_pkg::OP_READ: pending_reads.push_back(amps[pos]);
                default: ;
            endcase
        endfunction

        // Compare one read beat with the oldest pending read
        function void check_read(logic signed [15:0] re, logic signed [15:0] im);
            amp_t want;
            if (pending_reads.size() == 0)
            begin
                errors++;
                if (shown < 10)
                    $display("unexpected read beat: re=%0d im=%0d", re, im);
                shown++;
                return;
            end
            want = pending_reads.pop_front();
            if (re !== want.re || im !== want.im)
            begin
                errors++;
                if (shown < 10)
                    $display("read mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                             want.re, want.im, re, im);
                shown++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic [9:0]         index;
    logic signed [15:0] write_re;
    logic signed [15:0] write_im;
    logic [2:0]         gate;
    logic [3:0]         target;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;
    logic               read_valid;
    logic signed [15:0] read_re;
    logic signed [15:0] read_im;

    state_vector_model sb = new();
    int calm_left = 0;

    qubit_gate_state_vector_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .index      (index),
        .write_re   (write_re),
        .write_im   (write_im),
        .gate       (gate),
        .target     (target),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .read_valid (read_valid),
        .read_re    (read_re),
        .read_im    (read_im)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Check every read beat at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && read_valid !== 1'b0)
            sb.check_read(read_re, read_im);
    end

    // Amplitude value, biased toward the extremes
    function automatic logic signed [15:0] pick_amp();
        case ($urandom_range(0, 15))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one command beat from a falling edge, hold until accepted,
    // and return at the next falling edge with start still high
    task automatic send_beat(input logic [1:0] o, input logic [9:0] ix,
                             input logic signed [15:0] wre, input logic signed [15:0] wim,
                             input logic [2:0] g, input logic [3:0] tgt);
        op = o;
        index = ix;
        write_re = wre;
        write_im = wim;
        gate = g;
        target = tgt;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_beat(o, ix, wre, wim, g, tgt);
        @(negedge clk);
    endtask

    task automatic write_amp(input logic [9:0] ix, input logic signed [15:0] re,
                             input logic signed [15:0] im);
        send_beat(qgse_pkg::OP_WRITE, ix, re, im, 3'($urandom), 4'($urandom));
    endtask

    task automatic apply_gate(input logic [2:0] g, input logic [3:0] tgt);
        send_beat(qgse_pkg::OP_GATE, 10'($urandom), pick_amp(), pick_amp(), g, tgt);
    endtask

    task automatic read_amp(input logic [9:0] ix);
        send_beat(qgse_pkg::OP_READ, ix, pick_amp(), pick_amp(), 3'($urandom),
                  4'($urandom));
    endtask

    // Read the first written entry at or after ix
    task automatic read_known(input int ix);
        int j;
        j = sb.pick_known(ix);
        if (j >= 0)
            read_amp(10'(j));
    endtask

    // Drop start for a random gap with noise on the fields; mostly short,
    // a few long, and now and then a calm stretch with no gaps at all
    task automatic idle_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else if (r < 3)
            calm_left = $urandom_range(15, 40);
        else if (r < 45)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 96)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            start = 1'b0;
            op = 2'($urandom);
            index = 10'($urandom);
            write_re = 16'($urandom);
            write_im = 16'($urandom);
            gate = 3'($urandom);
            target = 4'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Wait until all reads are back and the gate walk has drained
    task automatic drain_idle();
        start = 1'b0;
        while (sb.pending_count() != 0 || busy !== 1'b0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_qubits(input logic [3:0] v);
        cfg_wdata = v;
        cfg_we = 1'b1;
        sb.set_qubits(v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // One random beat; counted is low for the unused op code.
    // Reads go to written entries only, with noise in the masked index bits.
    task automatic random_beat(output bit counted);
        int r;
        int q;
        int j;
        logic [3:0] tgt;
        r = $urandom_range(0, 99);
        q = sb.live_qubits();
        tgt = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, q - 1))
                                           : 4'($urandom_range(0, 15));
        counted = 1'b1;
        if (r < 30)
            write_amp(10'($urandom), pick_amp(), pick_amp());
        else if (r < 58)
            apply_gate(3'($urandom), tgt);
        else if (r < 95)
        begin
            j = sb.pick_known(int'($urandom_range(0, 1023)));
            if (j < 0)
                write_amp(10'($urandom), pick_amp(), pick_amp());
            else
                read_amp(10'(j | (int'($urandom_range(0, 1023)) & ~((1 << q) - 1))));
        end
        else
        begin
            send_beat(qgse_pkg::OP_NONE, 10'($urandom), pick_amp(), pick_amp(),
                      3'($urandom), tgt);
            counted = 1'b0;
        end
    endtask

    logic [3:0] phase_q [7] = '{4'd1, 4'd4, 4'd0, 4'd10, 4'd15, 4'd7, 4'd2};

    initial
    begin
        int p;
        int done_items;
        bit counted;
        rst_n = 1'b0;
        start = 1'b0;
        op = qgse_pkg::OP_WRITE;
        index = '0;
        write_re = '0;
        write_im = '0;
        gate = qgse_pkg::G_X;
        target = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Full store size; only entries holding written data are read back
        write_qubits(4'd10);

        // Directed: extremes, saturated negation, every gate, out-of-range target
        // and the unused op code
        write_amp(10'd0, 16'sh8000, 16'sh7FFF);
        write_amp(10'd1023, 16'sh7FFF, 16'sh8000);
        read_amp(10'd0);
        read_amp(10'd1023);
        write_amp(10'd1, 16'sh8000, 16'sh8000);
        idle_gap();
        apply_gate(qgse_pkg::G_Z, 4'd0);
        read_amp(10'd1);
        read_amp(10'd1023);
        write_amp(10'd2, 16'sd8192, 16'sd8192);
        write_amp(10'd3, 16'sd8192, 16'sd8192);
        apply_gate(qgse_pkg::G_H, 4'd0);
        read_amp(10'd2);
        read_amp(10'd3);
        idle_gap();
        apply_gate(qgse_pkg::G_X, 4'd9);
        apply_gate(qgse_pkg::G_Y, 4'd5);
        apply_gate(qgse_pkg::G_S, 4'd3);
        apply_gate(qgse_pkg::G_SDG, 4'd1);
        apply_gate(qgse_pkg::G_T, 4'd7);
        apply_gate(qgse_pkg::G_TDG, 4'd2);
        apply_gate(qgse_pkg::G_H, 4'd12);
        send_beat(qgse_pkg::OP_NONE, 10'd5, 16'sh7FFF, 16'sh8000, qgse_pkg::G_Z, 4'd15);
        read_known(0);
        read_known(512);
        read_known(1023);

        // Random phases, one qubit count each
        for (p = 0; p < 7; p++)
        begin
            drain_idle();
            write_qubits(phase_q[p]);
            done_items = 0;
            while (done_items < 76)
            begin
                random_beat(counted);
                if (counted)
                    done_items++;
                idle_gap();
            end
        end

        drain_idle();
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial
    begin
        #20_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/qgse_pkg.sv
hdl/qubit_gate_state_vector_engine.sv
tb/tb.sv
